[hdl/deadband_position_actuator_control_core_defines.svh]
// Assertion macros shared by the deadband position actuator control core.
`ifndef DEADBAND_POSITION_ACTUATOR_CONTROL_CORE_DEFINES_SVH
`define DEADBAND_POSITION_ACTUATOR_CONTROL_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define DPAC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is asserted.
`define DPAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[hdl/dpac_pkg.sv]
// Types and constants of the deadband position actuator control core.
`default_nettype none

package dpac_pkg;

    localparam int POS_W     = 10;
    localparam int BAND_W    = 8;
    localparam int RUN_W     = 4;
    localparam int DRIVE_W   = 2;
    localparam int STATUS_W  = 2;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;

    // Opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TARGET = 1'b1;

    // Drive commands
    localparam logic [DRIVE_W-1:0] DRV_BRAKE = 2'd0;
    localparam logic [DRIVE_W-1:0] DRV_UP    = 2'd1;
    localparam logic [DRIVE_W-1:0] DRV_DOWN  = 2'd2;

    // Sample status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 2'd2;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_MIN_POS   = 2'd0;
    localparam logic [1:0] REG_MAX_POS   = 2'd1;
    localparam logic [1:0] REG_BAND      = 2'd2;
    localparam logic [1:0] REG_TO_LIMIT  = 2'd3;

    // Register reset values
    localparam logic [POS_W-1:0]  RST_MIN_POS  = 10'd0;
    localparam logic [POS_W-1:0]  RST_MAX_POS  = 10'd1023;
    localparam logic [BAND_W-1:0] RST_BAND     = 8'd0;
    localparam logic [RUN_W-1:0]  RST_TO_LIMIT = 4'd3;

    typedef struct packed {
        logic             opcode;
        logic [POS_W-1:0] sample_range;
        logic             sample_timed_out;
        logic [POS_W-1:0] target_value;
    } t_in_item;

    typedef struct packed {
        logic [DRIVE_W-1:0]  drive;
        logic                sensor_reset;
        logic [STATUS_W-1:0] sample_status;
        logic [POS_W-1:0]    position_now;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0]  min_position;
        logic [POS_W-1:0]  max_position;
        logic [BAND_W-1:0] band_width;
        logic [RUN_W-1:0]  timeout_limit;
    } t_cfg;

endpackage

`default_nettype wire

[hdl/dpac_regs.sv]
// APB configuration registers of the deadband position actuator control core.
`default_nettype none

module dpac_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [dpac_pkg::APB_AW-1:0] paddr,
    input  wire logic [dpac_pkg::APB_DW-1:0] pwdata,
    output logic      [dpac_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output dpac_pkg::t_cfg                  o_cfg
);
    import dpac_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_position  <= RST_MIN_POS;
            r_cfg.max_position  <= RST_MAX_POS;
            r_cfg.band_width    <= RST_BAND;
            r_cfg.timeout_limit <= RST_TO_LIMIT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MIN_POS:  r_cfg.min_position  <= pwdata[POS_W-1:0];
                REG_MAX_POS:  r_cfg.max_position  <= pwdata[POS_W-1:0];
                REG_BAND:     r_cfg.band_width    <= pwdata[BAND_W-1:0];
                REG_TO_LIMIT: r_cfg.timeout_limit <= pwdata[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_MIN_POS:  prdata[POS_W-1:0]  = r_cfg.min_position;
            REG_MAX_POS:  prdata[POS_W-1:0]  = r_cfg.max_position;
            REG_BAND:     prdata[BAND_W-1:0] = r_cfg.band_width;
            REG_TO_LIMIT: prdata[RUN_W-1:0]  = r_cfg.timeout_limit;
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[hdl/dpac_step.sv]
// Controller state and the per-transaction update of position, timeout run and drive.
`default_nettype none

module dpac_step (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dpac_pkg::t_cfg     i_cfg,
    input  wire logic               i_fire,
    input  wire dpac_pkg::t_in_item i_item,
    output dpac_pkg::t_out_item     o_result
);
    import dpac_pkg::*;

    logic [POS_W-1:0]   r_held, n_held;
    logic [POS_W-1:0]   r_target, n_target;
    logic [RUN_W-1:0]   r_run, n_run;
    logic [DRIVE_W-1:0] r_drive, n_drive;

    logic                run_inc_ge;
    logic [RUN_W-1:0]    run_inc;
    logic                pulse;
    logic [STATUS_W-1:0] status;
    logic                below_tgt;
    logic [POS_W-1:0]    mag;
    logic [POS_W:0]      up_guard;
    logic [POS_W:0]      pos_plus_bw;
    logic [DRIVE_W-1:0]  drive_calc;

    assign run_inc    = r_run + 1'b1;
    assign run_inc_ge = (run_inc >= i_cfg.timeout_limit);

    // Sample handling: target load, timeout run, window check
    always_comb begin
        n_target = r_target;
        n_held   = r_held;
        n_run    = r_run;
        pulse    = 1'b0;
        status   = ST_OK;
        if (i_item.opcode == OP_TARGET) begin
            n_target = i_item.target_value;
        end else if (i_item.sample_timed_out) begin
            status = ST_TIMEOUT;
            if (run_inc_ge) begin
                pulse = 1'b1;
                n_run = '0;
            end else begin
                n_run = run_inc;
            end
        end else begin
            n_run = '0;
            if ((i_item.sample_range < i_cfg.min_position) ||
                (i_item.sample_range > i_cfg.max_position)) begin
                status = ST_OUT_RANGE;
            end else begin
                n_held = i_item.sample_range;
            end
        end
    end

    // Drive decision from the updated position; guard sums kept one bit wider
    assign below_tgt   = (r_target < n_held);
    assign mag         = below_tgt ? (n_held - r_target) : (r_target - n_held);
    assign up_guard    = {1'b0, i_cfg.min_position} + {3'b000, i_cfg.band_width};
    assign pos_plus_bw = {1'b0, n_held} + {3'b000, i_cfg.band_width};

    always_comb begin
        if (mag <= {2'b00, i_cfg.band_width}) begin
            drive_calc = DRV_BRAKE;
        end else if (below_tgt) begin
            drive_calc = ({1'b0, n_held} <= up_guard) ? DRV_BRAKE : DRV_UP;
        end else begin
            drive_calc = (pos_plus_bw >= {1'b0, i_cfg.max_position}) ? DRV_BRAKE : DRV_DOWN;
        end
    end

    // A target load leaves the drive as it was
    assign n_drive = (i_item.opcode == OP_TARGET) ? r_drive : drive_calc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_target <= '0;
            r_run    <= '0;
            r_drive  <= DRV_BRAKE;
        end else if (i_fire) begin
            r_held   <= n_held;
            r_target <= n_target;
            r_run    <= n_run;
            r_drive  <= n_drive;
        end
    end

    assign o_result.drive         = n_drive;
    assign o_result.sensor_reset  = pulse;
    assign o_result.sample_status = status;
    assign o_result.position_now  = n_held;

endmodule

`default_nettype wire

[hdl/deadband_position_actuator_control_core.sv]
// Top level of the deadband position actuator control core.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+-------------------------
//  input   | in        | i_in_valid/o_in_ready  | i_in_item  (t_in_item)
//  output  | out       | o_out_valid/i_out_ready| o_out_item (t_out_item)
//  config  | in        | APB, pready tied high  | pwdata / prdata
//
// One transaction per cycle sustained while the receiver is ready; an accepted
// transaction sits in the input register, and the state update loads its result
// into the result register once that register is free.
// The input side keeps accepting while a result waits, until both the input
// register and the result register are full.
// Reset is synchronous, active low; it restores the register defaults, clears
// the held position, target, timeout run and sets the drive to brake.
`default_nettype none
`include "deadband_position_actuator_control_core_defines.svh"

module deadband_position_actuator_control_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire dpac_pkg::t_in_item          i_in_item,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output dpac_pkg::t_out_item              o_out_item,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dpac_pkg::APB_AW-1:0] paddr,
    input  wire logic [dpac_pkg::APB_DW-1:0] pwdata,
    output logic      [dpac_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);
    import dpac_pkg::*;

    t_cfg      cfg;
    t_in_item  r_in;
    logic      r_in_vld;
    t_out_item r_out;
    logic      r_out_vld;
    t_out_item step_res;
    logic      advance;

    dpac_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Move the held transaction into the result register when it is free
    assign advance    = r_in_vld & (~r_out_vld | i_out_ready);
    assign o_in_ready = ~r_in_vld | advance;

    dpac_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_result (step_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // Checks; the guard check covers timeout and rejected samples, whose drive is fresh
    `DPAC_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, o_out_valid)
    `DPAC_ASSERT_IMPL(a_pulse_on_timeout, i_clk, i_rst_n, o_out_valid && o_out_item.sensor_reset, o_out_item.sample_status == ST_TIMEOUT)
    `DPAC_ASSERT_IMPL(a_up_clear_of_guard, i_clk, i_rst_n, o_out_valid && (o_out_item.drive == DRV_UP) && (o_out_item.sample_status != ST_OK), ({1'b0, o_out_item.position_now} > ({1'b0, cfg.min_position} + {3'b000, cfg.band_width})) || !$stable(cfg))

endmodule

`default_nettype wire

[verif/deadband_position_actuator_control_core_tb.sv]
// Self-checking testbench for the deadband position actuator control core.
`default_nettype none

module deadband_position_actuator_control_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dpac_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 205;
    localparam int MAX_PRINTS   = 50;

    // Tracks controller state and the queue of predicted results.
    class dpac_scoreboard;
        logic [POS_W-1:0]   min_pos;
        logic [POS_W-1:0]   max_pos;
        logic [BAND_W-1:0]  band;
        logic [RUN_W-1:0]   to_limit;
        logic [POS_W-1:0]   held;
        logic [POS_W-1:0]   target;
        logic [RUN_W-1:0]   run;
        logic [DRIVE_W-1:0] drive_now;
        t_out_item          expected_q[$];
        int                 errors;

        function new();
            min_pos   = RST_MIN_POS;
            max_pos   = RST_MAX_POS;
            band      = RST_BAND;
            to_limit  = RST_TO_LIMIT;
            held      = '0;
            target    = '0;
            run       = '0;
            drive_now = DRV_BRAKE;
            errors    = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_MIN_POS:  min_pos  = value[POS_W-1:0];
                REG_MAX_POS:  max_pos  = value[POS_W-1:0];
                REG_BAND:     band     = value[BAND_W-1:0];
                REG_TO_LIMIT: to_limit = value[RUN_W-1:0];
                default: ;
            endcase
        endfunction

        // Bang-bang decision with deadband and guard distance from both limits.
        function logic [DRIVE_W-1:0] pick_drive();
            int pos;
            int bw;
            int off;
            int mag;
            pos = int'(held);
            bw  = int'(band);
            off = int'(target) - pos;
            mag = (off < 0) ? -off : off;
            if (mag <= bw) return DRV_BRAKE;
            if (off < 0) begin
                if (pos <= int'(min_pos) + bw) return DRV_BRAKE;
                return DRV_UP;
            end
            if (pos >= int'(max_pos) - bw) return DRV_BRAKE;
            return DRV_DOWN;
        endfunction

        function void note_input(t_in_item it);
            t_out_item res;
            res.sensor_reset  = 1'b0;
            res.sample_status = ST_OK;
            if (it.opcode == OP_TARGET) begin
                target = it.target_value;
            end else begin
                if (it.sample_timed_out) begin
                    res.sample_status = ST_TIMEOUT;
                    run = run + 1'b1;
                    if (run >= to_limit) begin
                        res.sensor_reset = 1'b1;
                        run = '0;
                    end
                end else begin
                    run = '0;
                    if (it.sample_range < min_pos || it.sample_range > max_pos)
                        res.sample_status = ST_OUT_RANGE;
                    else
                        held = it.sample_range;
                end
                drive_now = pick_drive();
            end
            res.drive        = drive_now;
            res.position_now = held;
            expected_q.push_back(res);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item exp_res;
            if (expected_q.size() == 0) begin
                report($sformatf("result %p with no transaction pending", got));
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.drive !== exp_res.drive)
                report($sformatf("drive got %0d want %0d", got.drive, exp_res.drive));
            if (got.sensor_reset !== exp_res.sensor_reset)
                report($sformatf("sensor_reset got %0d want %0d",
                                 got.sensor_reset, exp_res.sensor_reset));
            if (got.sample_status !== exp_res.sample_status)
                report($sformatf("sample_status got %0d want %0d",
                                 got.sample_status, exp_res.sample_status));
            if (got.position_now !== exp_res.position_now)
                report($sformatf("position_now got %0d want %0d",
                                 got.position_now, exp_res.position_now));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_item            i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_item           o_out_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    dpac_scoreboard      sb;
    int                  cycles;
    bit                  gaps_on;
    bit                  stall_on;

    deadband_position_actuator_control_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result checking on each output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
    end

    // Receiver backpressure in random bursts while stall_on is set
    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready = 1'b0;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                stall_left  = $urandom_range(0, 7);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    function automatic logic [POS_W-1:0] clamp_pos(int v);
        if (v < 0) return '0;
        if (v > 1023) return 10'd1023;
        return v[POS_W-1:0];
    endfunction

    function automatic t_in_item mk_sample(int range, bit timed_out);
        t_in_item it;
        it.opcode           = OP_SAMPLE;
        it.sample_range     = clamp_pos(range);
        it.sample_timed_out = timed_out;
        it.target_value     = POS_W'($urandom_range(0, 1023));
        return it;
    endfunction

    function automatic t_in_item mk_target(int value);
        t_in_item it;
        it.opcode           = OP_TARGET;
        it.sample_range     = POS_W'($urandom_range(0, 1023));
        it.sample_timed_out = 1'($urandom_range(0, 1));
        it.target_value     = clamp_pos(value);
        return it;
    endfunction

    // Random item, biased toward the brake and guard boundaries
    function automatic t_in_item random_item();
        int sel;
        int pick;
        int bw;
        sel = $urandom_range(0, 99);
        bw  = int'(sb.band);
        if (sel < 30) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) return mk_target($urandom_range(0, 1023));
            return mk_target(int'(sb.held) + ($urandom_range(0, 1) ? bw : -bw)
                             + $urandom_range(0, 2) - 1);
        end
        if (sel < 45) return mk_sample($urandom_range(0, 1023), 1'b1);
        if (sel < 52 || sb.min_pos > sb.max_pos)
            return mk_sample($urandom_range(0, 1023), 1'b0);
        pick = $urandom_range(0, 9);
        case (pick)
            0: return mk_sample(int'(sb.min_pos) + bw + $urandom_range(0, 2) - 1, 1'b0);
            1: return mk_sample(int'(sb.max_pos) - bw + $urandom_range(0, 2) - 1, 1'b0);
            2: return mk_sample(int'(sb.min_pos) - $urandom_range(0, 1), 1'b0);
            3: return mk_sample(int'(sb.max_pos) + $urandom_range(0, 1), 1'b0);
            default: return mk_sample($urandom_range(sb.min_pos, sb.max_pos), 1'b0);
        endcase
    endfunction

    // Drive one input transaction, with an optional idle burst ahead of it
    task automatic send_item(t_in_item it);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
        @(negedge i_clk);
    endtask

    // Stop the input side and let every pending result drain
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // APB write: setup then access phase
    task automatic apb_write(logic [1:0] idx, logic [APB_DW-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_all(int min_v, int max_v, int band_v, int limit_v);
        wait_idle();
        apb_write(REG_MIN_POS, APB_DW'(min_v));
        apb_write(REG_MAX_POS, APB_DW'(max_v));
        apb_write(REG_BAND, APB_DW'(band_v));
        apb_write(REG_TO_LIMIT, APB_DW'(limit_v));
    endtask

    // Main sequence
    initial begin
        int a;
        int b;
        sb         = new();
        gaps_on    = 1'b1;
        stall_on   = 1'b1;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: default registers, field extremes, drive after target change
        send_item(mk_sample(0, 1'b0));
        send_item(mk_target(1023));
        send_item(mk_sample(1023, 1'b0));
        send_item(mk_sample(500, 1'b0));
        send_item(mk_target(0));
        // timeouts recompute drive on held position; third one pulses
        repeat (3) send_item(mk_sample($urandom_range(0, 1023), 1'b1));

        // Narrow window with the widest band
        write_all(300, 700, 255, 15);
        send_item(mk_sample(299, 1'b0));
        send_item(mk_sample(701, 1'b0));
        send_item(mk_sample(300, 1'b0));
        send_item(mk_target(1023));
        send_item(mk_sample(700, 1'b0));
        repeat (5) send_item(mk_sample($urandom_range(0, 1023), 1'b1));

        // Limit lowered below the current run
        wait_idle();
        apb_write(REG_TO_LIMIT, 2);
        send_item(mk_sample($urandom_range(0, 1023), 1'b1));

        // Limit of zero
        wait_idle();
        apb_write(REG_TO_LIMIT, 0);
        send_item(mk_sample($urandom_range(0, 1023), 1'b1));

        // Empty window rejects every good reading
        write_all(800, 100, 10, 3);
        send_item(mk_sample(500, 1'b0));
        send_item(mk_sample(800, 1'b0));
        send_item(mk_sample(100, 1'b0));

        // Random phases, each with its own register setting
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: write_all(0, 1023, 0, 1);
                1: write_all(0, 1023, 255, 15);
                2: write_all($urandom_range(512, 1023), $urandom_range(0, 511),
                             $urandom_range(0, 255), $urandom_range(1, 15));
                3: write_all($urandom_range(0, 300), $urandom_range(700, 1023),
                             $urandom_range(0, 40), 0);
                default: begin
                    a = $urandom_range(0, 1023);
                    b = $urandom_range(0, 1023);
                    write_all((a < b) ? a : b, (a < b) ? b : a,
                              $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 30),
                              $urandom_range(1, 15));
                end
            endcase
            if (p == PHASES - 1) begin
                gaps_on  = 1'b0;
                stall_on = 1'b0;
            end else begin
                gaps_on  = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
            end
            repeat (PHASE_ITEMS) send_item(random_item());
        end

        // Drain and finish
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (5) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+hdl
hdl/dpac_pkg.sv
hdl/dpac_regs.sv
hdl/dpac_step.sv
hdl/deadband_position_actuator_control_core.sv
verif/deadband_position_actuator_control_core_tb.sv
